// ----- rtl/ptd_pkg.sv -----
// Package for the trial-division primality tester.
// Holds the number width, counter width, FSM/phase types and divisor constants.
// No dependencies.
`default_nettype none

package ptd_pkg;

  localparam int NUM_WIDTH = 32;
  localparam int CNT_W     = $clog2(NUM_WIDTH);

  localparam logic [NUM_WIDTH-1:0] DIV_THREE = NUM_WIDTH'(3);
  localparam logic [NUM_WIDTH-1:0] FIRST_DIV = NUM_WIDTH'(5);
  localparam logic [NUM_WIDTH-1:0] PAIR_GAP  = NUM_WIDTH'(2);
  localparam logic [NUM_WIDTH-1:0] DIV_STEP  = NUM_WIDTH'(6);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_TRIV,
    ST_DIV,
    ST_EVAL,
    ST_DONE
  } ptd_state_t;

  // which divisor the running division belongs to
  typedef enum logic [1:0] {
    PH_THREE,
    PH_LO,
    PH_HI
  } ptd_phase_t;

endpackage

`default_nettype wire

// ----- rtl/primality_trial_division.sv -----
// Top level of the trial-division primality tester (6k-1 / 6k+1 divisors).
// Depends on ptd_pkg; contains the controller and a bit-serial restoring divider.
`default_nettype none

// Channel  Ports                                   Word
// -------  --------------------------------------  ------------------------------
// in       in_valid, in_ready, in_candidate        NUM_WIDTH-bit unsigned number
// out      out_valid, out_ready, out_is_prime_flag 1 = prime, 0 = not prime
//
// Flow: one word at a time. A value up to 3 or an even value goes through accept,
//   classify and hand-off; every other word runs trial divisions, each one quotient
//   bit a cycle and then a check, so a prime takes 2 + 2 * pairs divisions,
//   pairs about sqrt(n) / 6.
// Reset: synchronous, active low; clears the FSM and the output valid only.
// Stalls: the result sits in the output register, so a new word is taken while
//   it waits; a finished second result holds in ST_DONE until out is free.

module primality_trial_division (
  input  wire                          clk,
  input  wire                          rst_n,
  input  wire                          in_valid,
  output logic                         in_ready,
  input  wire  [ptd_pkg::NUM_WIDTH-1:0] in_candidate,
  output logic                         out_valid,
  input  wire                          out_ready,
  output logic                         out_is_prime_flag
);

  import ptd_pkg::*;

  ptd_state_t state_r, state_nxt;
  ptd_phase_t ph_r;

  logic [NUM_WIDTH-1:0] n_r;     // candidate under test
  logic [NUM_WIDTH-1:0] d_r;     // current 6k-1 divisor
  logic [NUM_WIDTH-1:0] dvs_r;   // divisor of the running division
  logic [NUM_WIDTH-1:0] rem_r;   // partial remainder
  logic [NUM_WIDTH-1:0] q_r;     // dividend bits out, quotient bits in
  logic [CNT_W-1:0]     cnt_r;
  logic                 res_r;
  logic                 out_valid_r;
  logic                 out_flag_r;

  // control from the output decoder
  logic                 capture;
  logic                 start_div;
  logic [NUM_WIDTH-1:0] start_dvs;
  ptd_phase_t           start_ph;
  logic                 load_d;
  logic [NUM_WIDTH-1:0] d_nxt;
  logic                 set_res;
  logic                 res_nxt;
  logic                 emit;

  // divider step
  logic [NUM_WIDTH:0]   trial;
  logic                 borrow;

  assign trial  = {rem_r, q_r[NUM_WIDTH-1]} - {1'b0, dvs_r};
  assign borrow = trial[NUM_WIDTH];

  assign in_ready          = (state_r == ST_IDLE);
  assign out_valid         = out_valid_r;
  assign out_is_prime_flag = out_flag_r;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) state_nxt = ST_TRIV;
      end
      ST_TRIV: begin
        if (n_r <= DIV_THREE || !n_r[0]) state_nxt = ST_DONE;
        else                             state_nxt = ST_DIV;
      end
      ST_DIV: begin
        if (cnt_r == '0) state_nxt = ST_EVAL;
      end
      ST_EVAL: begin
        if (rem_r == '0 || (ph_r == PH_LO && d_r > q_r)) state_nxt = ST_DONE;
        else                                             state_nxt = ST_DIV;
      end
      ST_DONE: begin
        if (!out_valid_r || out_ready) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    capture   = 1'b0;
    start_div = 1'b0;
    start_dvs = DIV_THREE;
    start_ph  = PH_THREE;
    load_d    = 1'b0;
    d_nxt     = d_r;
    set_res   = 1'b0;
    res_nxt   = 1'b0;
    emit      = 1'b0;
    case (state_r)
      ST_IDLE: begin
        capture = in_valid;
      end
      ST_TRIV: begin
        if (n_r <= DIV_THREE) begin
          set_res = 1'b1;
          res_nxt = (n_r > NUM_WIDTH'(1));
        end else if (!n_r[0]) begin
          set_res = 1'b1;
          res_nxt = 1'b0;
        end else begin
          start_div = 1'b1;
        end
      end
      ST_EVAL: begin
        case (ph_r)
          PH_THREE: begin
            if (rem_r == '0) begin
              set_res = 1'b1;
            end else begin
              start_div = 1'b1;
              start_dvs = FIRST_DIV;
              start_ph  = PH_LO;
              load_d    = 1'b1;
              d_nxt     = FIRST_DIV;
            end
          end
          PH_LO: begin
            if (d_r > q_r) begin
              // bound passed: d*d > n
              set_res = 1'b1;
              res_nxt = 1'b1;
            end else if (rem_r == '0) begin
              set_res = 1'b1;
            end else begin
              start_div = 1'b1;
              start_dvs = d_r + PAIR_GAP;
              start_ph  = PH_HI;
            end
          end
          PH_HI: begin
            if (rem_r == '0) begin
              set_res = 1'b1;
            end else begin
              start_div = 1'b1;
              start_dvs = d_r + DIV_STEP;
              start_ph  = PH_LO;
              load_d    = 1'b1;
              d_nxt     = d_r + DIV_STEP;
            end
          end
          default: set_res = 1'b1;
        endcase
      end
      ST_DONE: begin
        emit = !out_valid_r || out_ready;
      end
      default: ;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (emit)                       out_valid_r <= 1'b1;
      else if (out_valid_r && out_ready) out_valid_r <= 1'b0;
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (capture) n_r <= in_candidate;
    if (load_d)  d_r <= d_nxt;
    if (set_res) res_r <= res_nxt;
    if (emit)    out_flag_r <= res_r;
    if (start_div) begin
      dvs_r <= start_dvs;
      ph_r  <= start_ph;
      rem_r <= '0;
      q_r   <= n_r;
      cnt_r <= CNT_W'(NUM_WIDTH - 1);
    end else if (state_r == ST_DIV) begin
      rem_r <= borrow ? {rem_r[NUM_WIDTH-2:0], q_r[NUM_WIDTH-1]} : trial[NUM_WIDTH-1:0];
      q_r   <= {q_r[NUM_WIDTH-2:0], ~borrow};
      cnt_r <= cnt_r - CNT_W'(1);
    end
  end

  // checks
  a_rem_below_dvs: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_DIV |-> rem_r < dvs_r)
    else $error("partial remainder not below divisor");

  a_take_to_triv: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> state_r == ST_TRIV)
    else $error("accepted word not classified next");

  a_div_ends: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_DIV && cnt_r == '0 |=> state_r == ST_EVAL)
    else $error("division overran its bit count");

  a_lo_dvs: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_EVAL && ph_r == PH_LO |-> dvs_r == d_r)
    else $error("6k-1 division used the wrong divisor");

  a_prime_odd: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_DONE && res_r |-> n_r[0] || n_r == NUM_WIDTH'(2))
    else $error("even value above two flagged prime");

endmodule

`default_nettype wire

// ----- verif/ptd_checker.sv -----
// Scoreboard for the trial-division primality tester: watches both channels,
// predicts each verdict by its own trial division and compares on the out side.
// Depends on ptd_pkg for NUM_WIDTH.

module ptd_checker (
  input  wire                          clk,
  input  wire                          rst_n,
  input  wire                          in_valid,
  input  wire                          in_ready,
  input  wire [ptd_pkg::NUM_WIDTH-1:0] in_candidate,
  input  wire                          out_valid,
  input  wire                          out_ready,
  input  wire                          out_is_prime_flag,
  output int                           fail_count,
  output int                           outstanding,
  output int                           results_seen,
  output int                           primes_seen
);

  import ptd_pkg::*;

  typedef struct packed {
    logic [NUM_WIDTH-1:0] cand;
    logic                 flag;
  } verdict_t;

  verdict_t verdict_q[$];
  int       errs;
  int       seen;
  int       primes;

  // 6k-1 / 6k+1 trial division; bound kept as d <= n / d so nothing overflows
  function automatic logic trial_divide(input logic [NUM_WIDTH-1:0] cand);
    longint unsigned n;
    longint unsigned d;
    n = 64'(cand);
    if (n <= 3) return n > 1;
    if (n % 2 == 0 || n % 3 == 0) return 1'b0;
    d = 5;
    while (d <= n / d) begin
      if (n % d == 0 || n % (d + 2) == 0) return 1'b0;
      d += 6;
    end
    return 1'b1;
  endfunction

  always @(posedge clk) begin
    verdict_t head;
    if (rst_n) begin
      // retire first: a word can never produce its verdict on its own accept edge
      if (out_valid && out_ready) begin
        if (verdict_q.size() == 0) begin
          $error("result with no word outstanding: is_prime_flag %0b", out_is_prime_flag);
          errs++;
        end else begin
          head = verdict_q.pop_front();
          seen++;
          if (head.flag) primes++;
          if (out_is_prime_flag !== head.flag) begin
            $error("is_prime_flag mismatch for candidate %0d: expected %0b, actual %0b",
                   head.cand, head.flag, out_is_prime_flag);
            errs++;
          end
        end
      end
      if (in_valid && in_ready)
        verdict_q.push_back('{cand: in_candidate, flag: trial_divide(in_candidate)});
    end
    fail_count   <= errs;
    outstanding  <= verdict_q.size();
    results_seen <= seen;
    primes_seen  <= primes;
  end

endmodule

// ----- verif/tb.sv -----
// Testbench top for primality_trial_division: drives candidate words, throttles
// the result side and gives the verdict. Depends on ptd_pkg and ptd_checker.

module tb;
  import ptd_pkg::*;

  // A prime near 2^32 tests divisor pairs to its root with no handshake, so the
  // watchdog sits well clear of that; the tail covers a trivial word's latency.
  localparam int WATCHDOG_LIMIT = 3_000_000;
  localparam int TAIL_CYCLES    = 64;
  localparam int IDLE_PCT       = 17;

  logic                 clk          = 1'b0;
  logic                 rst_n        = 1'b0;
  logic                 in_valid     = 1'b0;
  logic                 in_ready;
  logic [NUM_WIDTH-1:0] in_candidate = '0;
  logic                 out_valid;
  logic                 out_ready    = 1'b0;
  logic                 out_is_prime_flag;

  bit src_idle_en  = 1'b1;
  bit sink_idle_en = 1'b1;
  int quiet_cycles = 0;

  int fail_count;
  int outstanding;
  int results_seen;
  int primes_seen;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  primality_trial_division u_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_candidate      (in_candidate),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_is_prime_flag (out_is_prime_flag)
  );

  ptd_checker u_checker (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_candidate      (in_candidate),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_is_prime_flag (out_is_prime_flag),
    .fail_count        (fail_count),
    .outstanding       (outstanding),
    .results_seen      (results_seen),
    .primes_seen       (primes_seen)
  );

  // Result side: ready drops at random unless the no-idle stretch is running.
  always @(posedge clk) begin
    out_ready <= !sink_idle_en || ($urandom_range(0, 99) >= IDLE_PCT);
  end

  // Watchdog: counts cycles in which neither channel moves a word.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // Offer one word. An idle gap lowers valid, waiting an edge before raising it, so
  // valid never sees two assignments in one step; it then holds until taken.
  task automatic send_word(input logic [NUM_WIDTH-1:0] cand);
    while (src_idle_en && $urandom_range(0, 99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_candidate <= cand;
    do @(posedge clk); while (!in_ready);
  endtask

  // Stop sending and let every verdict come home. The extra edge lets the
  // checker's count catch the word accepted on the edge we returned on.
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  function automatic int unsigned pick_factor();
    case ($urandom_range(0, 11))
      0:       return 2;
      1:       return 3;
      2:       return 5;
      3:       return 7;
      4:       return 11;
      5:       return 13;
      6:       return 17;
      7:       return 19;
      8:       return 23;
      9:       return 29;
      10:      return 31;
      default: return 37;
    endcase
  endfunction

  // Cost of a word grows with its smallest factor (sqrt(n) for primes), so big
  // numbers are only ever built with a small factor; primes stay below 2^20.
  function automatic logic [NUM_WIDTH-1:0] pick_candidate();
    int unsigned roll;
    int unsigned raw;
    int unsigned fac;
    int unsigned lo_odd;
    int unsigned hi_odd;
    roll = $urandom_range(0, 99);
    if (roll < 40) begin
      return NUM_WIDTH'($urandom_range(0, 65535));
    end else if (roll < 60) begin
      return NUM_WIDTH'($urandom_range(0, 1 << 20));
    end else if (roll < 85) begin
      // full-width word rounded down to a multiple of a low prime
      raw = $urandom;
      fac = pick_factor();
      return NUM_WIDTH'((raw / fac) * fac);
    end else begin
      // product of two odd numbers: survives the 2/3 screen fairly often
      lo_odd = 2 * $urandom_range(50, 500) + 1;
      hi_odd = 2 * $urandom_range(50, 500) + 1;
      return NUM_WIDTH'(lo_odd * hi_odd);
    end
  endfunction

  initial begin
    logic [NUM_WIDTH-1:0] corner_words[$];

    // Trivial values, small primes and composites, squares that land exactly
    // on the divisor bound (5^2, 11^2, 13^2 hitting the +2 divisor, 31^2),
    // both divisors of a pair, the top of the range and the largest 32-bit prime.
    corner_words = '{32'd0, 32'd1, 32'd2, 32'd3, 32'd4, 32'd5, 32'd6, 32'd7,
                     32'd8, 32'd9, 32'd25, 32'd35, 32'd49, 32'd121, 32'd143,
                     32'd169, 32'd961, 32'd65536, 32'd65537, 32'd1000003,
                     32'h8000_0000, 32'hFFFF_FFFE, 32'hFFFF_FFFF,
                     32'd4294836225, 32'd4294967291};

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (corner_words[i]) send_word(corner_words[i]);

    // hold off completely until the pipe is empty before the random words
    drain();

    repeat (25) send_word(pick_candidate());

    // long stretch with neither side idling
    src_idle_en  = 1'b0;
    sink_idle_en = 1'b0;
    repeat (25) send_word(pick_candidate());
    src_idle_en  = 1'b1;
    sink_idle_en = 1'b1;

    repeat (25) send_word(pick_candidate());

    drain();
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Checked %0d verdicts (%0d prime): trivial and boundary-square words,",
             results_seen, primes_seen);
    $display("full-width composites, the largest 32-bit prime, random small and semiprime words.");
    if (fail_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
